// ===== hw/rtl/ort_pkg.sv =====
// Ordered record table: shared types, request and status codes.
// No dependencies; the cell, the controller and the top import this package.
package ort_pkg;

   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_INSERT = 3'd1;
   localparam logic [2:0] REQ_APPEND = 3'd2;
   localparam logic [2:0] REQ_DELETE = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;
   localparam logic [2:0] REQ_FIND   = 3'd5;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_BAD_POS  = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [15:0] key_high;
      logic [63:0] key_low;
      logic [63:0] name_word0;
      logic [63:0] name_word1;
      logic [31:0] name_word2;
      logic [7:0]  age;
   } record_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      record_type  wr;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] found_position;
      logic [7:0] length;
      record_type rec;
   } rsp_type;

endpackage

// ===== hw/rtl/ort_req_if.sv =====
// Request channel of the ordered record table: valid/ready plus request fields.
// No dependencies.
interface ort_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  position;
   logic [15:0] key_high;
   logic [63:0] key_low;
   logic [63:0] name_word0;
   logic [63:0] name_word1;
   logic [31:0] name_word2;
   logic [7:0]  age;

   modport source (output valid, req_type, position, key_high, key_low,
                   name_word0, name_word1, name_word2, age, input ready);
   modport sink (input valid, req_type, position, key_high, key_low,
                 name_word0, name_word1, name_word2, age, output ready);
endinterface

// ===== hw/rtl/ort_rsp_if.sv =====
// Response channel of the ordered record table: valid/ready plus result fields.
// No dependencies.
interface ort_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  found_position;
   logic [7:0]  length;
   logic [15:0] out_key_high;
   logic [63:0] out_key_low;
   logic [63:0] out_name_word0;
   logic [63:0] out_name_word1;
   logic [31:0] out_name_word2;
   logic [7:0]  out_age;

   modport source (output valid, status, found_position, length, out_key_high,
                   out_key_low, out_name_word0, out_name_word1, out_name_word2,
                   out_age, input ready);
   modport sink (input valid, status, found_position, length, out_key_high,
                 out_key_low, out_name_word0, out_name_word1, out_name_word2,
                 out_age, output ready);
endinterface

// ===== hw/rtl/ort_cell.sv =====
// One storage cell of the record chain: holds a record, takes new data,
// its left or its right neighbor's record. Depends on ort_pkg.
module ort_cell
   import ort_pkg::*;
#(
   parameter int TABLE_DEPTH = 128,
   parameter int CELL_INDEX  = 0,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [AW-1:0] index,
   input  record_type    left_rec,
   input  record_type    right_rec,
   output record_type    rec
);

   localparam logic [AW-1:0] MY_INDEX = AW'(CELL_INDEX);

   record_type rec_ff;
   record_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_INDEX == index) begin
               rec_in = ctrl.wr;
            end else if (MY_INDEX > index) begin
               rec_in = left_rec;
            end
         end
         CELL_DELETE: begin
            if (MY_INDEX >= index) begin
               rec_in = right_rec;
            end
         end
         CELL_ROTATE: rec_in = right_rec;
         default:     rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

// ===== hw/rtl/ort_ctrl.sv =====
// Ordered record table controller: request decode, length, ring scan for
// read and find, two-entry response queue. Depends on ort_pkg, ort_req_if, ort_rsp_if.
module ort_ctrl
   import ort_pkg::*;
#(
   parameter int TABLE_DEPTH = 128,
   localparam int AW = $clog2(TABLE_DEPTH),
   localparam int CW = $clog2(TABLE_DEPTH + 1),
   localparam int PW = (CW > 8) ? CW : 8
) (
   input  logic          clock,
   input  logic          reset,
   ort_req_if.sink       req_chan,
   ort_rsp_if.source     rsp_chan,
   input  record_type    head_rec,
   output cell_ctrl_type cell_ctrl,
   output logic [AW-1:0] cell_index
);

   localparam logic [AW-1:0] LAST_STEP = AW'(TABLE_DEPTH - 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] step_ff, step_in;
   logic          is_find_ff, is_find_in;
   logic          hit_ff, hit_in;
   logic [PW-1:0] found_ff, found_in;
   logic [AW-1:0] target_ff, target_in;
   logic [79:0]   key_ff, key_in;
   record_type    rd_rec_ff, rd_rec_in;
   rsp_type       q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]    qcnt_ff, qcnt_in;

   record_type    req_rec;
   logic          accept, push, pop, start_scan, last_step, cur_hit;
   rsp_type       rsp_new;
   logic [PW-1:0] pos_ext, pos_m1, count_ext, len_w, step_w;
   logic          pos_zero, full;

   assign req_rec.key_high   = req_chan.key_high;
   assign req_rec.key_low    = req_chan.key_low;
   assign req_rec.name_word0 = req_chan.name_word0;
   assign req_rec.name_word1 = req_chan.name_word1;
   assign req_rec.name_word2 = req_chan.name_word2;
   assign req_rec.age        = req_chan.age;

   assign req_chan.ready = (state_ff == ST_IDLE) && (qcnt_ff != 2'd2);
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext   = PW'(req_chan.position);
   assign pos_m1    = pos_ext - PW'(1);
   assign pos_zero  = (req_chan.position == 8'd0);
   assign count_ext = PW'(count_ff);
   assign full      = (count_ext >= PW'(TABLE_DEPTH));
   assign last_step = (step_ff == LAST_STEP);
   assign step_w    = PW'(step_ff) + PW'(1);
   assign cur_hit   = is_find_ff && !hit_ff && (CW'(step_ff) < count_ff)
                      && (head_rec.key_high == key_ff[79:64])
                      && (head_rec.key_low == key_ff[63:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && start_scan) state_in = ST_SCAN;
         ST_SCAN: if (last_step) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cell_ctrl.op = CELL_HOLD;
      cell_ctrl.wr = req_rec;
      cell_index   = pos_m1[AW-1:0];
      count_in     = count_ff;
      step_in      = step_ff;
      is_find_in   = is_find_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      target_in    = target_ff;
      key_in       = key_ff;
      rd_rec_in    = rd_rec_ff;
      start_scan   = 1'b0;
      push         = 1'b0;
      rsp_new      = '0;
      len_w        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push = 1'b1;
               case (req_chan.req_type)
                  REQ_CLEAR: count_in = '0;
                  REQ_INSERT: begin
                     if (full) begin
                        rsp_new.status = STAT_FULL;
                     end else if (pos_zero || (pos_m1 > count_ext)) begin
                        rsp_new.status = STAT_BAD_POS;
                     end else begin
                        cell_ctrl.op = CELL_INSERT;
                        count_in     = count_ff + CW'(1);
                     end
                  end
                  REQ_APPEND: begin
                     if (full) begin
                        rsp_new.status = STAT_FULL;
                     end else begin
                        cell_ctrl.op = CELL_INSERT;
                        cell_index   = count_ff[AW-1:0];
                        count_in     = count_ff + CW'(1);
                     end
                  end
                  REQ_DELETE: begin
                     if (pos_zero || (pos_ext > count_ext)) begin
                        rsp_new.status = STAT_BAD_POS;
                     end else begin
                        cell_ctrl.op = CELL_DELETE;
                        count_in     = count_ff - CW'(1);
                     end
                  end
                  REQ_READ: begin
                     if (pos_zero || (pos_ext > count_ext)) begin
                        rsp_new.status = STAT_BAD_POS;
                     end else begin
                        push       = 1'b0;
                        start_scan = 1'b1;
                        is_find_in = 1'b0;
                        target_in  = pos_m1[AW-1:0];
                     end
                  end
                  REQ_FIND: begin
                     push       = 1'b0;
                     start_scan = 1'b1;
                     is_find_in = 1'b1;
                     key_in     = {req_chan.key_high, req_chan.key_low};
                  end
                  default: rsp_new.status = STAT_OK;
               endcase
               step_in  = '0;
               hit_in   = 1'b0;
               found_in = '0;
               len_w    = PW'(count_in);
               rsp_new.length = len_w[7:0];
            end
         end
         ST_SCAN: begin
            cell_ctrl.op = CELL_ROTATE;
            step_in      = step_ff + AW'(1);
            if (cur_hit) begin
               hit_in   = 1'b1;
               found_in = step_w;
            end
            if (!is_find_ff && (step_ff == target_ff)) begin
               rd_rec_in = head_rec;
            end
            if (last_step) begin
               push  = 1'b1;
               len_w = count_ext;
               rsp_new.length = len_w[7:0];
               if (is_find_ff) begin
                  rsp_new.status         = hit_in ? STAT_OK : STAT_NOTFOUND;
                  rsp_new.found_position = found_in[7:0];
               end else begin
                  rsp_new.rec = rd_rec_in;
               end
            end
         end
         default: cell_ctrl.op = CELL_HOLD;
      endcase
   end

   // response queue
   assign pop = (qcnt_ff != 2'd0) && rsp_chan.ready;

   always_comb begin
      q0_in   = q0_ff;
      q1_in   = q1_ff;
      qcnt_in = qcnt_ff + {1'b0, push} - {1'b0, pop};
      if (push && ((qcnt_ff == 2'd0) || ((qcnt_ff == 2'd1) && pop))) begin
         q0_in = rsp_new;
      end else if (pop && (qcnt_ff == 2'd2)) begin
         q0_in = q1_ff;
      end
      if (push && (qcnt_ff == 2'd1) && !pop) begin
         q1_in = rsp_new;
      end
   end

   assign rsp_chan.valid          = (qcnt_ff != 2'd0);
   assign rsp_chan.status         = q0_ff.status;
   assign rsp_chan.found_position = q0_ff.found_position;
   assign rsp_chan.length         = q0_ff.length;
   assign rsp_chan.out_key_high   = q0_ff.rec.key_high;
   assign rsp_chan.out_key_low    = q0_ff.rec.key_low;
   assign rsp_chan.out_name_word0 = q0_ff.rec.name_word0;
   assign rsp_chan.out_name_word1 = q0_ff.rec.name_word1;
   assign rsp_chan.out_name_word2 = q0_ff.rec.name_word2;
   assign rsp_chan.out_age        = q0_ff.rec.age;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         qcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         qcnt_ff  <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      is_find_ff <= is_find_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      target_ff  <= target_in;
      key_ff     <= key_in;
      rd_rec_ff  <= rd_rec_in;
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
   end

endmodule

// ===== hw/rtl/ordered_record_table_top.sv =====
// Ordered record table top: controller plus a ring of TABLE_DEPTH record cells.
// Clear, insert, append, delete and bad-position requests: the result enters
// the response queue the cycle after acceptance; one request per cycle while
// the response queue is not full. Read and find: the ring rotates every record
// past the compare at cell 0, and the next request waits until the scan ends.
// Reset (synchronous): length zero, response queue empty; records are not cleared.
module ordered_record_table_top
   import ort_pkg::*;
#(
   parameter int TABLE_DEPTH = 128
) (
   input  logic      clock,
   input  logic      reset,
   ort_req_if.sink   req_chan,
   ort_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(TABLE_DEPTH);

   cell_ctrl_type cell_ctrl;
   logic [AW-1:0] cell_index;
   record_type    cell_rec [TABLE_DEPTH];

   ort_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .head_rec   (cell_rec[0]),
      .cell_ctrl  (cell_ctrl),
      .cell_index (cell_index)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ort_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .index     (cell_index),
         .left_rec  (cell_rec[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
         .right_rec (cell_rec[(i + 1) % TABLE_DEPTH]),
         .rec       (cell_rec[i])
      );
   end

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (cell_ctrl.op == CELL_ROTATE) |-> !(req_chan.valid && req_chan.ready))
      else $error("request accepted during ring scan");

   a_scan_starts_on_request: assert property (@(posedge clock) disable iff (reset)
      $rose(cell_ctrl.op == CELL_ROTATE) |-> $past(req_chan.valid && req_chan.ready))
      else $error("ring scan started without a request");

   a_notfound_no_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != STAT_OK)) |->
      (rsp_chan.found_position == 8'd0))
      else $error("found position reported with a failing status");

endmodule
